FILE: rtl/tpci_pkg.sv
// ----------------------------------------------------------------------------
// tpci_pkg: shared types and constants of the pulse charge integrator
// word formats, command codes and widths used by the front, queue and back
// ----------------------------------------------------------------------------
package tpci_pkg;

    localparam int SAMPLE_WIDTH = 24;
    localparam int TIME_WIDTH   = 32;
    localparam int THRESH_WIDTH = SAMPLE_WIDTH - 1;
    localparam int ACC_WIDTH    = 63;
    localparam int COUNT_WIDTH  = 32;
    localparam int MAG_WIDTH    = SAMPLE_WIDTH;
    localparam int PROD_WIDTH   = SAMPLE_WIDTH + TIME_WIDTH - 1;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_WIDTH   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_WIDTH   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [THRESH_WIDTH-1:0] THRESH_RESET = THRESH_WIDTH'(13107);
    localparam logic [ACC_WIDTH-1:0]    ACC_MAX      = {ACC_WIDTH{1'b1}};
    localparam logic [COUNT_WIDTH-1:0]  COUNT_MAX    = {COUNT_WIDTH{1'b1}};

    typedef struct packed {
        logic [TIME_WIDTH-1:0]          sample_time;
        logic signed [SAMPLE_WIDTH-1:0] total_current;
        logic signed [SAMPLE_WIDTH-1:0] electron_current;
        logic signed [SAMPLE_WIDTH-1:0] ion_current;
    } t_in_word;

    typedef struct packed {
        logic [ACC_WIDTH-1:0]   ion_charge;
        logic [ACC_WIDTH-1:0]   electron_charge;
        logic [ACC_WIDTH-1:0]   total_charge;
        logic [COUNT_WIDTH-1:0] pulse_number;
        logic                   time_order_error;
    } t_out_word;

    typedef enum logic [1:0] {
        CMD_ACC  = 2'd0,
        CMD_EMIT = 2'd1,
        CMD_ERR  = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind              kind;
        logic [TIME_WIDTH-1:0]  dt;
        logic [MAG_WIDTH-1:0]   mag_ion;
        logic [MAG_WIDTH-1:0]   mag_electron;
        logic [MAG_WIDTH-1:0]   mag_total;
        logic [COUNT_WIDTH-1:0] count;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_push;

    function automatic logic [MAG_WIDTH-1:0] magnitude(input logic [SAMPLE_WIDTH-1:0] raw);
        logic [MAG_WIDTH-1:0] neg;
        neg = MAG_WIDTH'(~raw) + MAG_WIDTH'(1);
        return raw[SAMPLE_WIDTH-1] ? neg : MAG_WIDTH'(raw);
    endfunction

endpackage

FILE: rtl/tpci_front.sv
// ----------------------------------------------------------------------------
// tpci_front: sample intake and pulse classification
// tracks time order, threshold crossings and pulse count, issues commands
// ----------------------------------------------------------------------------
module tpci_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_accept,
    input  tpci_pkg::t_in_word                 i_word,
    input  logic                               i_cfg_we,
    input  logic [tpci_pkg::THRESH_WIDTH-1:0]  i_cfg_data,
    output tpci_pkg::t_push                    o_push
);

    logic [tpci_pkg::THRESH_WIDTH-1:0] r_threshold;
    logic [tpci_pkg::TIME_WIDTH-1:0]   r_prev_time, n_prev_time;
    logic [tpci_pkg::COUNT_WIDTH-1:0]  r_pulse_cnt, n_pulse_cnt;
    logic                              r_in_pulse, n_in_pulse;
    logic                              r_halted, n_halted;

    logic                              w_backwards;
    logic                              w_above;
    logic [tpci_pkg::MAG_WIDTH-1:0]    w_mag_total;

    assign w_backwards = i_word.sample_time < r_prev_time;
    assign w_mag_total = tpci_pkg::magnitude(i_word.total_current);
    assign w_above     = w_mag_total > tpci_pkg::MAG_WIDTH'(r_threshold);

    always_comb begin
        n_prev_time = r_prev_time;
        n_pulse_cnt = r_pulse_cnt;
        n_in_pulse  = r_in_pulse;
        n_halted    = r_halted;
        o_push.valid            = 1'b0;
        o_push.cmd.kind         = tpci_pkg::CMD_ACC;
        o_push.cmd.dt           = i_word.sample_time - r_prev_time;
        o_push.cmd.mag_ion      = tpci_pkg::magnitude(i_word.ion_current);
        o_push.cmd.mag_electron = tpci_pkg::magnitude(i_word.electron_current);
        o_push.cmd.mag_total    = w_mag_total;
        o_push.cmd.count        = r_pulse_cnt;
        if (i_accept && !r_halted) begin
            if (w_backwards) begin
                n_halted        = 1'b1;
                o_push.valid    = 1'b1;
                o_push.cmd.kind = tpci_pkg::CMD_ERR;
            end else begin
                n_prev_time = i_word.sample_time;
                if (w_above) begin
                    o_push.valid = 1'b1;
                    if (!r_in_pulse) begin
                        n_in_pulse = 1'b1;
                        if (r_pulse_cnt != tpci_pkg::COUNT_MAX) begin
                            n_pulse_cnt = r_pulse_cnt + tpci_pkg::COUNT_WIDTH'(1);
                        end
                    end
                end else if (r_in_pulse) begin
                    n_in_pulse      = 1'b0;
                    o_push.valid    = 1'b1;
                    o_push.cmd.kind = tpci_pkg::CMD_EMIT;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= tpci_pkg::THRESH_RESET;
            r_prev_time <= '0;
            r_pulse_cnt <= '0;
            r_in_pulse  <= 1'b0;
            r_halted    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_threshold <= i_cfg_data;
            end
            r_prev_time <= n_prev_time;
            r_pulse_cnt <= n_pulse_cnt;
            r_in_pulse  <= n_in_pulse;
            r_halted    <= n_halted;
        end
    end

endmodule

FILE: rtl/tpci_queue.sv
// ----------------------------------------------------------------------------
// tpci_queue: command queue between front and back
// small first-in first-out buffer so each side can stall on its own
// ----------------------------------------------------------------------------
module tpci_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tpci_pkg::t_push i_push,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output tpci_pkg::t_cmd  o_cmd
);

    tpci_pkg::t_cmd                  r_mem [tpci_pkg::QUEUE_DEPTH];
    logic [tpci_pkg::QPTR_WIDTH-1:0] r_wr_ptr;
    logic [tpci_pkg::QPTR_WIDTH-1:0] r_rd_ptr;
    logic [tpci_pkg::QCNT_WIDTH-1:0] r_count;

    logic w_wr;
    logic w_rd;

    assign o_full  = r_count == tpci_pkg::QCNT_WIDTH'(tpci_pkg::QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_mem[r_rd_ptr];
    assign w_wr    = i_push.valid && !o_full;
    assign w_rd    = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_push.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + tpci_pkg::QPTR_WIDTH'(1);
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + tpci_pkg::QPTR_WIDTH'(1);
            end
            case ({w_wr, w_rd})
                2'b10:   r_count <= r_count + tpci_pkg::QCNT_WIDTH'(1);
                2'b01:   r_count <= r_count - tpci_pkg::QCNT_WIDTH'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: rtl/tpci_back.sv
// ----------------------------------------------------------------------------
// tpci_back: charge multiply and accumulate
// registered current times time step products, saturating accumulators and
// the result word register
// ----------------------------------------------------------------------------
module tpci_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  tpci_pkg::t_cmd       i_q_cmd,
    output logic                 o_q_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output tpci_pkg::t_out_word  o_out_word
);

    localparam int FULL_PROD = tpci_pkg::MAG_WIDTH + tpci_pkg::TIME_WIDTH;
    localparam int SUM_WIDTH = tpci_pkg::ACC_WIDTH + 1;

    logic                              r_m_valid;
    tpci_pkg::t_cmd_kind               r_m_kind;
    logic [tpci_pkg::PROD_WIDTH-1:0]   r_m_prod_ion;
    logic [tpci_pkg::PROD_WIDTH-1:0]   r_m_prod_electron;
    logic [tpci_pkg::PROD_WIDTH-1:0]   r_m_prod_total;
    logic [tpci_pkg::COUNT_WIDTH-1:0]  r_m_count;

    logic [tpci_pkg::ACC_WIDTH-1:0]    r_acc_ion, n_acc_ion;
    logic [tpci_pkg::ACC_WIDTH-1:0]    r_acc_electron, n_acc_electron;
    logic [tpci_pkg::ACC_WIDTH-1:0]    r_acc_total, n_acc_total;
    logic                              r_out_valid;
    tpci_pkg::t_out_word               r_out_word;

    logic [FULL_PROD-1:0]              w_full_ion;
    logic [FULL_PROD-1:0]              w_full_electron;
    logic [FULL_PROD-1:0]              w_full_total;
    logic [SUM_WIDTH-1:0]              w_sum_ion;
    logic [SUM_WIDTH-1:0]              w_sum_electron;
    logic [SUM_WIDTH-1:0]              w_sum_total;
    logic                              w_m_adv;

    assign w_full_ion      = FULL_PROD'(i_q_cmd.mag_ion) * FULL_PROD'(i_q_cmd.dt);
    assign w_full_electron = FULL_PROD'(i_q_cmd.mag_electron) * FULL_PROD'(i_q_cmd.dt);
    assign w_full_total    = FULL_PROD'(i_q_cmd.mag_total) * FULL_PROD'(i_q_cmd.dt);

    assign w_m_adv = r_m_valid
                     && (r_m_kind == tpci_pkg::CMD_ACC || !r_out_valid || i_out_ready);
    assign o_q_pop = i_q_valid && (!r_m_valid || w_m_adv);

    assign w_sum_ion      = SUM_WIDTH'(r_acc_ion) + SUM_WIDTH'(r_m_prod_ion);
    assign w_sum_electron = SUM_WIDTH'(r_acc_electron) + SUM_WIDTH'(r_m_prod_electron);
    assign w_sum_total    = SUM_WIDTH'(r_acc_total) + SUM_WIDTH'(r_m_prod_total);

    // saturate on carry out of the accumulator width
    always_comb begin
        n_acc_ion      = w_sum_ion[SUM_WIDTH-1] ? tpci_pkg::ACC_MAX
                                                : w_sum_ion[tpci_pkg::ACC_WIDTH-1:0];
        n_acc_electron = w_sum_electron[SUM_WIDTH-1] ? tpci_pkg::ACC_MAX
                                                     : w_sum_electron[tpci_pkg::ACC_WIDTH-1:0];
        n_acc_total    = w_sum_total[SUM_WIDTH-1] ? tpci_pkg::ACC_MAX
                                                  : w_sum_total[tpci_pkg::ACC_WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_m_kind          <= i_q_cmd.kind;
            r_m_prod_ion      <= w_full_ion[tpci_pkg::PROD_WIDTH-1:0];
            r_m_prod_electron <= w_full_electron[tpci_pkg::PROD_WIDTH-1:0];
            r_m_prod_total    <= w_full_total[tpci_pkg::PROD_WIDTH-1:0];
            r_m_count         <= i_q_cmd.count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_m_adv && r_m_kind != tpci_pkg::CMD_ACC) begin
            r_out_word.pulse_number <= r_m_count;
            if (r_m_kind == tpci_pkg::CMD_EMIT) begin
                r_out_word.ion_charge       <= r_acc_ion;
                r_out_word.electron_charge  <= r_acc_electron;
                r_out_word.total_charge     <= r_acc_total;
                r_out_word.time_order_error <= 1'b0;
            end else begin
                r_out_word.ion_charge       <= '0;
                r_out_word.electron_charge  <= '0;
                r_out_word.total_charge     <= '0;
                r_out_word.time_order_error <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid      <= 1'b0;
            r_out_valid    <= 1'b0;
            r_acc_ion      <= '0;
            r_acc_electron <= '0;
            r_acc_total    <= '0;
        end else begin
            if (o_q_pop) begin
                r_m_valid <= 1'b1;
            end else if (w_m_adv) begin
                r_m_valid <= 1'b0;
            end
            if (w_m_adv && r_m_kind != tpci_pkg::CMD_ACC) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_m_adv) begin
                case (r_m_kind)
                    tpci_pkg::CMD_ACC: begin
                        r_acc_ion      <= n_acc_ion;
                        r_acc_electron <= n_acc_electron;
                        r_acc_total    <= n_acc_total;
                    end
                    tpci_pkg::CMD_EMIT: begin
                        r_acc_ion      <= '0;
                        r_acc_electron <= '0;
                        r_acc_total    <= '0;
                    end
                    default: begin
                        r_acc_ion      <= r_acc_ion;
                        r_acc_electron <= r_acc_electron;
                        r_acc_total    <= r_acc_total;
                    end
                endcase
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

FILE: rtl/threshold_pulse_charge_integrator.sv
// ----------------------------------------------------------------------------
// threshold_pulse_charge_integrator: threshold gated pulse charge integrator
// integrates absolute current times time step per channel over each pulse
// ----------------------------------------------------------------------------
// Takes one sample word per clock while the queue has room. A pulse opens
// when |total_current| rises strictly above current_threshold and closes at
// the first sample at or below it; that closing sample produces one result
// word with the three saturating charges (units of 2^-16 current times ticks)
// and the pulse count. A sample whose time is earlier than the previous one
// gives an error word and the block ignores all later samples until reset.
// The command of the closing sample passes through the four-entry command
// queue, the multiplier register and the accumulate and result register. The
// accumulate stage takes one command per clock, so the block keeps one sample
// per cycle as long as results are taken; a waiting result stalls the back end
// only when a second result reaches it.
// ----------------------------------------------------------------------------
module threshold_pulse_charge_integrator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  tpci_pkg::t_in_word                 i_in_word,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output tpci_pkg::t_out_word                o_out_word,
    input  logic                               i_cfg_we,
    input  logic [tpci_pkg::THRESH_WIDTH-1:0]  i_cfg_data
);

    tpci_pkg::t_push w_push;
    tpci_pkg::t_cmd  w_q_cmd;
    logic            w_q_full;
    logic            w_q_valid;
    logic            w_q_pop;
    logic            w_accept;

    assign o_in_ready = !w_q_full;
    assign w_accept   = i_in_valid && o_in_ready;

    tpci_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_word     (i_in_word),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_push     (w_push)
    );

    tpci_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_q_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd)
    );

    tpci_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_cmd     (w_q_cmd),
        .o_q_pop     (w_q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    // a command is never issued into a full queue
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.valid |-> !w_q_full)
        else $error("command issued while queue full");

    // an error word carries no charge
    a_error_zero_charge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.time_order_error) |->
            (o_out_word.ion_charge == '0 && o_out_word.electron_charge == '0
             && o_out_word.total_charge == '0))
        else $error("error word with nonzero charge");

    // a closed pulse word always follows at least one counted pulse
    a_pulse_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_word.time_order_error) |-> o_out_word.pulse_number != '0)
        else $error("pulse word with zero pulse count");

    // the back end never pops an empty queue
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> w_q_valid)
        else $error("pop from empty queue");

endmodule
